/* src/rhh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_pkg
// shared constants and types for the robin hood hash table
// ----------------------------------------------------------------------------
package rhh_pkg;
    localparam int SLOTS      = 256;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int DIST_W     = IDX_W + 1;
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 32;
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [63:0]      hash;
        logic [VAL_W-1:0] value;
        logic [3:0]       len;
    } entry_t;

    // hash unit handshake
    typedef struct packed {
        logic start;
        logic done;
    } hash_ctl_t;
endpackage

/* src/rhh_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_hash
// byte-serial fnv-1a; the prime multiply is shifts and adds in 64 bits
// ----------------------------------------------------------------------------
module rhh_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [3:0]  len,
    output logic        done,
    output logic [63:0] hash
);
    import rhh_pkg::*;

    logic [63:0] h_reg, h_next, x;
    logic [3:0]  cnt_reg;
    logic [3:0]  len_reg;
    logic        busy_reg, done_reg;
    logic [2:0]  bsel;

    assign bsel = cnt_reg[2:0];
    always_comb
    begin
        x = h_reg ^ {56'd0, key[8*bsel +: 8]};
        // prime is 2^40 + 2^8 + 0xb3
        h_next = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
               + (x << 1) + x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            len_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                h_reg    <= FNV_BASIS;
                cnt_reg  <= '0;
                len_reg  <= len;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == len_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    h_reg   <= h_next;
                    cnt_reg <= cnt_reg + 4'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign hash = h_reg;
endmodule

/* src/robin_hood_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// fixed-capacity key/value table, robin hood probing, backward-shift delete
// ----------------------------------------------------------------------------
// Input beats carry mode, key_bytes, key_len and new_value on in_valid /
// in_ready; each gives one result beat of status, stored_value and
// live_count on out_valid / out_ready. The user must write max_reg through
// cfg_we / cfg_data only while idle; the block itself does not enforce it.
// One item at a time: in_ready is low from acceptance until its result
// is taken. An item's key is first hashed byte-serially, then the probe
// walk visits slots, each in a read state and then a compare or write
// state (the slot memory read is registered). An insert of a new key then
// walks again from its home slot up to the empty one; a delete then
// inspects the following slots for the backward shift. The next beat can
// be taken in the cycle after the result goes.
// Reset empties every slot at once (occupancy bits held in flops),
// sets the count to zero and the limit to 230. A stalled receiver just
// holds the result beat; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
module robin_hood_hash_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [63:0] key_bytes,
    input  logic [3:0]  key_len,
    input  logic [31:0] new_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] stored_value,
    output logic [7:0]  live_count,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data
);
    import rhh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_LREAD, S_LCHK, S_PREAD, S_PCHK,
        S_DREAD, S_DCHK, S_RESP
    } state_t;

    state_t state_reg;
    entry_t mem [SLOTS];
    logic [DIST_W-1:0] dist_reg [SLOTS];
    logic [SLOTS-1:0]  occ_reg;

    logic [1:0]  mode_reg;
    logic [63:0] key_reg;
    logic [3:0]  len_reg;
    logic [31:0] val_reg;
    logic [7:0]  max_reg, count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [DIST_W-1:0] probe_reg;
    entry_t carry_reg, rd_reg;
    logic [DIST_W-1:0] rdist_reg;
    logic rocc_reg;
    logic [1:0]  st_reg;
    logic [31:0] res_reg;

    hash_ctl_t hctl;
    logic [63:0] hash;
    logic [3:0]  len_sat;
    logic [63:0] key_mask;
    logic [IDX_W-1:0] idx_inc;

    assign len_sat = (key_len > 4'd8) ? 4'd8 : key_len;
    always_comb
    begin
        key_mask = '0;
        for (int b = 0; b < 8; b++)
            if (4'(b) < len_sat)
                key_mask[8*b +: 8] = 8'hff;
    end
    assign idx_inc = idx_reg + 1'b1;
    assign hctl.start = (state_reg == S_IDLE) && in_valid;

    // key is taken from the captured copy, the input may move on after the beat
    rhh_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hctl.start),
        .key   (key_reg),
        .len   (len_sat),
        .done  (hctl.done),
        .hash  (hash)
    );

    logic        wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t      wr_data;
    logic [DIST_W-1:0] wr_dist;
    logic        wr_occ;
    logic        wr_val_only;

    // slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[idx_reg];
        if (wr_en)
        begin
            if (wr_val_only)
                mem[wr_idx].value <= wr_data.value;
            else
                mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (wr_en && !wr_val_only)
            occ_reg[wr_idx] <= wr_occ;
    end

    always_ff @(posedge clk)
    begin
        rdist_reg <= dist_reg[idx_reg];
        rocc_reg  <= occ_reg[idx_reg];
        if (wr_en && !wr_val_only)
            dist_reg[wr_idx] <= wr_dist;
    end

    logic hit;
    assign hit = rocc_reg && rd_reg.hash == carry_reg.hash && rd_reg.len == carry_reg.len
              && rd_reg.key == carry_reg.key;

    logic [7:0] limit;
    assign limit = (max_reg > 8'(SLOTS - 1)) ? 8'(SLOTS - 1) : max_reg;

    always_comb
    begin
        wr_en = 1'b0; wr_idx = idx_reg; wr_data = carry_reg;
        wr_dist = probe_reg; wr_occ = 1'b1; wr_val_only = 1'b0;
        case (state_reg)
            S_LCHK:
                if (rocc_reg && rdist_reg >= probe_reg && hit && mode_reg == MODE_INSERT)
                begin
                    wr_en = 1'b1; wr_val_only = 1'b1;
                    wr_data.value = val_reg;
                end
            S_PCHK:
                if (!rocc_reg || rdist_reg < probe_reg)
                    wr_en = 1'b1;
            S_DCHK:
            begin
                wr_en = 1'b1;
                wr_idx = idx_reg - 1'b1;
                if (!rocc_reg || rdist_reg == '0)
                    wr_occ = 1'b0;
                else
                begin
                    wr_data = rd_reg;
                    wr_dist = rdist_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            max_reg   <= 8'd230;
            count_reg <= '0;
            probe_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                max_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        mode_reg <= mode;
                        key_reg  <= key_bytes & key_mask;
                        len_reg  <= len_sat;
                        val_reg  <= new_value;
                        state_reg <= S_HASH;
                    end
                S_HASH:
                    if (hctl.done)
                    begin
                        carry_reg <= '{key: key_reg, hash: hash, value: val_reg,
                                       len: len_reg};
                        idx_reg   <= hash[IDX_W-1:0];
                        probe_reg <= '0;
                        st_reg    <= ST_ABSENT;
                        res_reg   <= '0;
                        state_reg <= (mode_reg == MODE_UNUSED) ? S_RESP : S_LREAD;
                    end
                S_LREAD: state_reg <= S_LCHK;
                S_LCHK:
                    if (!rocc_reg || rdist_reg < probe_reg || probe_reg == DIST_W'(SLOTS))
                    begin
                        // key is absent
                        if (mode_reg == MODE_INSERT)
                        begin
                            if (count_reg >= limit)
                            begin
                                st_reg <= ST_FULL;
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                st_reg <= ST_OK;
                                count_reg <= count_reg + 8'd1;
                                idx_reg <= carry_reg.hash[IDX_W-1:0];
                                probe_reg <= '0;
                                state_reg <= S_PREAD;
                            end
                        end
                        else
                            state_reg <= S_RESP;
                    end
                    else if (hit)
                    begin
                        st_reg  <= ST_OK;
                        res_reg <= rd_reg.value;
                        if (mode_reg == MODE_DELETE)
                        begin
                            count_reg <= count_reg - 8'd1;
                            idx_reg   <= idx_inc;
                            state_reg <= S_DREAD;
                        end
                        else
                            state_reg <= S_RESP;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        probe_reg <= probe_reg + 1'b1;
                        state_reg <= S_LREAD;
                    end
                S_PREAD: state_reg <= S_PCHK;
                S_PCHK:
                    if (!rocc_reg)
                        state_reg <= S_RESP;
                    else
                    begin
                        // swap with richer slot, carry the evicted entry on
                        if (rdist_reg < probe_reg)
                        begin
                            carry_reg <= rd_reg;
                            probe_reg <= rdist_reg + 1'b1;
                        end
                        else
                            probe_reg <= probe_reg + 1'b1;
                        idx_reg   <= idx_inc;
                        state_reg <= S_PREAD;
                    end
                S_DREAD: state_reg <= S_DCHK;
                S_DCHK:
                    if (!rocc_reg || rdist_reg == '0)
                        state_reg <= S_RESP;
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_DREAD;
                    end
                S_RESP:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_RESP);
    assign status       = st_reg;
    assign stored_value = res_reg;
    assign live_count   = count_reg;

    a_hash_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        hctl.start |-> state_reg == S_IDLE)
        else $error("hash started while busy");
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 8'(SLOTS - 1))
        else $error("live count beyond capacity");
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(stored_value))
        else $error("result beat changed while stalled");
    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP && st_reg == ST_FULL |-> $stable(count_reg))
        else $error("count moved on a refused insert");
endmodule
